/* design/dew_point_pump_guard_macros.svh */
// ---------------------------------------------------------------------------
// dew point pump guard assertion macros
// shared concurrent assertion forms for the guard logic
// ---------------------------------------------------------------------------
`ifndef DEW_POINT_PUMP_GUARD_MACROS_SVH
`define DEW_POINT_PUMP_GUARD_MACROS_SVH

// same-cycle implication, held off during reset
`define DPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define DPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dpg_pkg.sv */
// ---------------------------------------------------------------------------
// dpg_pkg
// constants, types and the log table of the dew point pump guard
// ---------------------------------------------------------------------------
package dpg_pkg;

    localparam int LnEntries = 256;
    localparam int TabW      = $clog2(LnEntries + 1);
    localparam int PW        = 14 + TabW;

    // shared bit-serial divider
    localparam int DivNW = 48;
    localparam int DivDW = 30;
    localparam int CntW  = $clog2(DivNW + 1);

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] RegDewMargin  = 3'd0;
    localparam logic [CfgIdxW-1:0] RegOutThr     = 3'd1;
    localparam logic [CfgIdxW-1:0] RegComfort    = 3'd2;
    localparam logic [CfgIdxW-1:0] RegHysteresis = 3'd3;
    localparam logic [CfgIdxW-1:0] RegValidLow   = 3'd4;
    localparam logic [CfgIdxW-1:0] RegValidHigh  = 3'd5;

    localparam int Ln2Q16     = 45426;
    localparam int Ln10000Q16 = 603609;
    localparam int DewInvalid = -10000;
    localparam int MagnusA    = 1762;
    localparam int MagnusB    = 24312;
    localparam int DewScale   = 2431200;
    localparam int DenBase    = 115474432;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP1,
        S_DIV1,
        S_NORM,
        S_LN,
        S_ALPHA,
        S_PREP2,
        S_DIV2,
        S_DEW,
        S_FIN
    } t_state;

    typedef logic [15:0] t_lnt [0:LnEntries];

    // restoring shift-subtract quotient, used only while building the table
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned dvs);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            q = q << 1;
            if (r >= dvs) begin
                r = r - dvs;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // ln(1 + i/N) in Q16 by the atanh series, done at elaboration
    function automatic t_lnt build_lnt();
        t_lnt tab;
        longint unsigned n;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned k;
        n = longint'(LnEntries);
        for (int i = 0; i <= LnEntries; i++) begin
            z    = udiv(longint'(i) << 30, 2 * n + longint'(i));
            z2   = (z * z) >> 30;
            term = z;
            sum  = 0;
            k    = 1;
            for (int j = 0; j < 200; j++) begin
                if (term != 0) begin
                    sum  = sum + udiv(term, k);
                    term = (term * z2) >> 30;
                    k    = k + 2;
                end
            end
            tab[i] = 16'((2 * sum + 8192) >> 14);
        end
        return tab;
    endfunction

    localparam t_lnt Lnt = build_lnt();

endpackage

/* design/dpg_intf.sv */
// ---------------------------------------------------------------------------
// dpg channel interfaces
// snapshot input, result output and register write channels
// ---------------------------------------------------------------------------
interface dpg_in_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] outdoor_dew_point;
    logic signed [14:0] indoor_temp;
    logic        [13:0] indoor_humidity;
    logic signed [14:0] outdoor_temp;
    logic signed [15:0] pipe_temp;
    logic signed [15:0] water_temp;

    modport source (
        output valid, outdoor_dew_point, indoor_temp, indoor_humidity,
               outdoor_temp, pipe_temp, water_temp,
        input  ready
    );
    modport sink (
        input  valid, outdoor_dew_point, indoor_temp, indoor_humidity,
               outdoor_temp, pipe_temp, water_temp,
        output ready
    );
endinterface

interface dpg_out_if;
    logic               valid;
    logic               ready;
    logic               pumps_on;
    logic signed [15:0] ref_dew_point;
    logic signed [15:0] water_floor;
    logic               weather_demand;
    logic               indoor_demand;

    modport source (
        output valid, pumps_on, ref_dew_point, water_floor, weather_demand,
               indoor_demand,
        input  ready
    );
    modport sink (
        input  valid, pumps_on, ref_dew_point, water_floor, weather_demand,
               indoor_demand,
        output ready
    );
endinterface

interface dpg_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [dpg_pkg::CfgIdxW-1:0]  index;
    logic [dpg_pkg::CfgDataW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* design/dew_point_pump_guard.sv */
// flow: an accepted item with humidity in range runs two bit-serial divisions, with the normalize
//   shifts, log lookup and alpha step between them; other humidity goes straight to the result
// items: one item at a time; the next item is taken once the result is registered
// the shared restoring divider produces one quotient bit per cycle
// reset: synchronous active low; configuration registers return to their defaults, pumps off, no result
// ---------------------------------------------------------------------------
// dew_point_pump_guard
// magnus dew point with condensation guard and pump hysteresis
// ---------------------------------------------------------------------------
`include "dew_point_pump_guard_macros.svh"

module dew_point_pump_guard (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dpg_in_if.sink         i_in,
    dpg_out_if.source      o_out,
    dpg_cfg_if.sink        i_cfg
);

    dpg_pkg::t_state r_state, n_state;

    logic signed [14:0] r_odp, r_tin, r_tout;
    logic        [13:0] r_hum;
    logic signed [15:0] r_pipe, r_water;

    logic        [10:0] r_dew_margin, r_hyst;
    logic signed [13:0] r_out_thr, r_comfort;
    logic signed [14:0] r_vlow, r_vhigh;

    logic [dpg_pkg::DivNW-1:0] r_dvd;
    logic [dpg_pkg::DivDW-1:0] r_rem, r_dvs;
    logic [dpg_pkg::CntW-1:0]  r_cnt;
    logic                      r_neg;

    logic signed [25:0] r_term1, r_alpha;
    logic        [14:0] r_hn;
    logic        [3:0]  r_e;
    logic [dpg_pkg::PW-1:0] r_p;
    logic        [16:0] r_lm;
    logic signed [19:0] r_idp;
    logic               r_pump;
    logic               r_out_valid;

    logic               div_last;
    logic [dpg_pkg::DivDW:0] rem_sh;
    logic               q_bit;
    logic               hum_bad;
    logic               out_free;

    // ---------------- bit-serial divider step
    always_comb begin
        rem_sh   = {r_rem, r_dvd[dpg_pkg::DivNW-1]};
        q_bit    = rem_sh >= {1'b0, r_dvs};
        div_last = r_cnt == dpg_pkg::CntW'(dpg_pkg::DivNW - 1);
        hum_bad  = (r_hum == 14'd0) || (r_hum > 14'd10000);
        out_free = !r_out_valid || o_out.ready;
    end

    // ---------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dpg_pkg::S_IDLE:  if (i_in.valid) n_state = dpg_pkg::S_PREP1;
            dpg_pkg::S_PREP1: n_state = hum_bad ? dpg_pkg::S_FIN : dpg_pkg::S_DIV1;
            dpg_pkg::S_DIV1:  if (div_last) n_state = dpg_pkg::S_NORM;
            dpg_pkg::S_NORM:  if (r_hn[14]) n_state = dpg_pkg::S_LN;
            dpg_pkg::S_LN:    n_state = dpg_pkg::S_ALPHA;
            dpg_pkg::S_ALPHA: n_state = dpg_pkg::S_PREP2;
            dpg_pkg::S_PREP2: n_state = dpg_pkg::S_DIV2;
            dpg_pkg::S_DIV2:  if (div_last) n_state = dpg_pkg::S_DEW;
            dpg_pkg::S_DEW:   n_state = dpg_pkg::S_FIN;
            dpg_pkg::S_FIN:   if (out_free) n_state = dpg_pkg::S_IDLE;
            default:          n_state = dpg_pkg::S_IDLE;
        endcase
    end

    // ---------------- handshake outputs
    always_comb begin
        i_in.ready  = r_state == dpg_pkg::S_IDLE;
        i_cfg.ready = 1'b1;
        o_out.valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dpg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dew_margin <= 11'd200;
            r_out_thr    <= 14'sd2800;
            r_comfort    <= 14'sd2500;
            r_hyst       <= 11'd100;
            r_vlow       <= -15'sd5000;
            r_vhigh      <= 15'sd12500;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                dpg_pkg::RegDewMargin:  r_dew_margin <= i_cfg.data[10:0];
                dpg_pkg::RegOutThr:     r_out_thr    <= signed'(i_cfg.data[13:0]);
                dpg_pkg::RegComfort:    r_comfort    <= signed'(i_cfg.data[13:0]);
                dpg_pkg::RegHysteresis: r_hyst       <= i_cfg.data[10:0];
                dpg_pkg::RegValidLow:   r_vlow       <= signed'(i_cfg.data[14:0]);
                dpg_pkg::RegValidHigh:  r_vhigh      <= signed'(i_cfg.data[14:0]);
                default: ;
            endcase
        end
    end

    // ---------------- datapath
    logic        [14:0] t_mag;
    logic        [25:0] t_prod;
    logic signed [16:0] b_sum;
    logic        [22:0] d1;
    logic [dpg_pkg::TabW-1:0] li;
    logic        [13:0] lr;
    logic        [15:0] lo, hi, ldiff;
    logic        [29:0] lmul;
    logic signed [25:0] e_term;
    logic signed [32:0] den;
    logic        [25:0] a_mag;
    logic        [47:0] a_prod;
    logic signed [19:0] ref_v;
    logic signed [20:0] floor_v;
    logic signed [21:0] on_thr, cold_x, thr_x;
    logic               pipe_ok, water_ok, any_ok, wd, sd, on;
    logic signed [15:0] coldest;

    always_comb begin
        t_mag  = r_tin[14] ? 15'(-r_tin) : 15'(r_tin);
        t_prod = 26'(t_mag) * 26'(dpg_pkg::MagnusA);
        b_sum  = 17'(r_tin) + 17'sd24312;
        d1     = 23'($unsigned(b_sum)) * 23'd100;

        li = r_p[dpg_pkg::PW-1:14];
        if (li > dpg_pkg::TabW'(dpg_pkg::LnEntries - 1)) begin
            li = dpg_pkg::TabW'(dpg_pkg::LnEntries - 1);
        end
        lr    = r_p[13:0];
        lo    = dpg_pkg::Lnt[li];
        hi    = dpg_pkg::Lnt[li + dpg_pkg::TabW'(1)];
        ldiff = (hi >= lo) ? hi - lo : 16'd0;
        lmul  = 30'(ldiff) * 30'(lr);

        e_term = signed'(26'(20'(r_e) * 20'(dpg_pkg::Ln2Q16)));

        den    = 33'(dpg_pkg::DenBase) - 33'(r_alpha) * 33'sd100;
        a_mag  = r_alpha[25] ? 26'(-r_alpha) : 26'(r_alpha);
        a_prod = 48'(a_mag) * 48'(dpg_pkg::DewScale);

        ref_v   = (20'(r_odp) > r_idp) ? 20'(r_odp) : r_idp;
        floor_v = 21'(ref_v) + signed'({10'd0, r_dew_margin});
        on_thr  = 22'(floor_v) + signed'({11'd0, r_hyst});
        wd      = 15'(r_out_thr) < r_tout;
        sd      = 15'(r_comfort) < r_tin;
        pipe_ok  = (17'(r_pipe) > 17'(r_vlow)) && (17'(r_pipe) < 17'(r_vhigh));
        water_ok = (17'(r_water) > 17'(r_vlow)) && (17'(r_water) < 17'(r_vhigh));
        any_ok   = pipe_ok || water_ok;
        coldest  = r_pipe;
        if (water_ok && (!pipe_ok || r_water < r_pipe)) begin
            coldest = r_water;
        end
        cold_x = 22'(coldest);
        thr_x  = r_pump ? 22'(floor_v) : on_thr;
        on     = wd && sd && any_ok && (cold_x > thr_x);
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            dpg_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    r_odp   <= i_in.outdoor_dew_point;
                    r_tin   <= i_in.indoor_temp;
                    r_hum   <= i_in.indoor_humidity;
                    r_tout  <= i_in.outdoor_temp;
                    r_pipe  <= i_in.pipe_temp;
                    r_water <= i_in.water_temp;
                end
            end
            dpg_pkg::S_PREP1: begin
                r_dvd <= {6'd0, t_prod, 16'd0} + 48'(d1[22:1]);
                r_dvs <= 30'(d1);
                r_neg <= r_tin[14];
                r_rem <= '0;
                r_cnt <= '0;
                r_hn  <= {1'b0, r_hum};
                r_e   <= 4'd14;
                r_idp <= 20'(dpg_pkg::DewInvalid);
            end
            dpg_pkg::S_DIV1, dpg_pkg::S_DIV2: begin
                r_rem <= q_bit ? 30'(rem_sh - {1'b0, r_dvs}) : 30'(rem_sh);
                r_dvd <= {r_dvd[dpg_pkg::DivNW-2:0], q_bit};
                r_cnt <= r_cnt + dpg_pkg::CntW'(1);
            end
            dpg_pkg::S_NORM: begin
                r_term1 <= r_neg ? -signed'(26'(r_dvd[24:0])) : signed'(26'(r_dvd[24:0]));
                if (!r_hn[14]) begin
                    r_hn <= {r_hn[13:0], 1'b0};
                    r_e  <= r_e - 4'd1;
                end else begin
                    r_p <= dpg_pkg::PW'(r_hn[13:0]) * dpg_pkg::PW'(dpg_pkg::LnEntries);
                end
            end
            dpg_pkg::S_LN: begin
                r_lm <= 17'(lo) + 17'(lmul[29:14]);
            end
            dpg_pkg::S_ALPHA: begin
                r_alpha <= r_term1 + e_term + signed'(26'(r_lm))
                           - 26'sd603609;
            end
            dpg_pkg::S_PREP2: begin
                r_dvd <= a_prod + 48'(den[32:1]);
                r_dvs <= den[29:0];
                r_neg <= r_alpha[25];
                r_rem <= '0;
                r_cnt <= '0;
            end
            dpg_pkg::S_DEW: begin
                r_idp <= r_neg ? -signed'(20'(r_dvd[18:0])) : signed'(20'(r_dvd[18:0]));
            end
            default: ;
        endcase
    end

    // ---------------- result register and pump state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pump      <= 1'b0;
        end else begin
            if (r_state == dpg_pkg::S_FIN && out_free) begin
                r_out_valid <= 1'b1;
                r_pump      <= on;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == dpg_pkg::S_FIN && out_free) begin
            o_out.pumps_on       <= on;
            o_out.weather_demand <= wd;
            o_out.indoor_demand  <= sd;
            o_out.ref_dew_point  <= (ref_v > 20'sd32767) ? 16'sd32767 :
                                    (ref_v < -20'sd32768) ? -16'sd32768 : 16'(ref_v);
            o_out.water_floor    <= (floor_v > 21'sd32767) ? 16'sd32767 :
                                    (floor_v < -21'sd32768) ? -16'sd32768 : 16'(floor_v);
        end
    end

    // ---------------- checks
    `DPG_ASSERT_IMP(a_on_needs_demand, i_clk, i_rst_n, o_out.valid && o_out.pumps_on, o_out.weather_demand && o_out.indoor_demand, "pumps on without demand")
    `DPG_ASSERT_IMP(a_pump_tracks_out, i_clk, i_rst_n, r_out_valid, r_pump == o_out.pumps_on, "pump state differs from result")
    `DPG_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, i_in.valid && i_in.ready, r_state == dpg_pkg::S_PREP1, "accepted item did not start")
    `DPG_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, i_in.ready, r_state == dpg_pkg::S_IDLE, "ready while busy")

endmodule
